// File: src/wtc_pkg.sv
// Shared types, constants and widths of the wheel trip computer.
package wtc_pkg;

  // Storage widths of the trip counters
  localparam int DIST_WIDTH = 40;
  localparam int HOUR_WIDTH = 10;

  // Port widths
  localparam int CIRC_W      = 12;
  localparam int RATE_W      = 20;
  localparam int OP_W        = 3;
  localparam int PERIOD_W    = 32;
  localparam int SPEED_W     = 24;
  localparam int ACCEL_W     = 32;
  localparam int DIST_OUT_W  = 40;
  localparam int HOUR_OUT_W  = 10;
  localparam int MIN_W       = 6;
  localparam int SEC_W       = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 20;

  // Total trip seconds: hours*3600 + 3599 stays below 2^(HOUR_WIDTH+12)
  localparam int SECS_W = HOUR_WIDTH + 12;

  // Magnitude product |dv| * rate, and the shared divider widths
  localparam int PROD_W = SPEED_W + RATE_W;
  localparam int NUM_W  = (PROD_W + 12 > DIST_WIDTH + 4) ? PROD_W + 12 : DIST_WIDTH + 4;
  localparam int DEN_W  = (SECS_W + 5 > PERIOD_W + 5) ? SECS_W + 5 : PERIOD_W + 5;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  // Saturation limits
  localparam logic [SPEED_W-1:0]    SPEED_MAX   = '1;
  localparam logic [ACCEL_W-1:0]    ACC_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [ACCEL_W-1:0]    ACC_NEG_MAX = 32'h8000_0000;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX    = '1;
  localparam logic [HOUR_WIDTH-1:0] HOUR_MAX    = '1;
  localparam logic [SEC_W-1:0]      SEC_LAST    = 6'd59;
  localparam logic [MIN_W-1:0]      MIN_LAST    = 6'd59;

  // Configuration reset values
  localparam logic [CIRC_W-1:0] CIRC_RESET = 12'd1596;
  localparam logic [RATE_W-1:0] RATE_RESET = 20'd1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CIRC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 1'd1;

  // Event codes
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PULSE = 3'd1;
  localparam logic [OP_W-1:0] OP_PLAY  = 3'd2;
  localparam logic [OP_W-1:0] OP_PAUSE = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // Trip clock commands
  typedef struct packed {
    logic tick;
    logic clear;
  } clk_ctl_t;

endpackage

// File: src/wheel_trip_computer_unit.sv
// Top level of the wheel trip computer: event sequencer, trip state and result register.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid/in_ready     opcode, period_ticks
//   out_     output     out_valid/out_ready   speed, accel, distance, average, clock, flags
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// Tick, play, pause, stop and unused codes go from acceptance straight to the finish state.
// A wheel pulse sends the average, speed and acceleration quotients (NUM_W = 56) each
// through the one radix-2 divider, a bit per cycle.
// A zero period or a paused trip skips the divisions it does not need.
// Reset is synchronous, active low, and needs no clearing pass.
// A result waits in the output register; a new transaction is taken meanwhile and held
// at its end until the output register is free.
module wheel_trip_computer_unit
  import wtc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           in_opcode,
  input  logic [PERIOD_W-1:0]       in_period_ticks,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SPEED_W-1:0]        out_speed_centi_kmh,
  output logic signed [ACCEL_W-1:0] out_accel_centi_kmh_per_h,
  output logic [DIST_OUT_W-1:0]     out_trip_distance_mm,
  output logic [SPEED_W-1:0]        out_average_centi_kmh,
  output logic [HOUR_OUT_W-1:0]     out_trip_hour_count,
  output logic [MIN_W-1:0]          out_trip_minute_count,
  output logic [SEC_W-1:0]          out_trip_second_count,
  output logic                      out_is_running,
  output logic                      out_error_flag,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST,
    S_AVG,
    S_AVG_WAIT,
    S_SPD,
    S_SPD_WAIT,
    S_ACC_MUL,
    S_ACC,
    S_ACC_WAIT,
    S_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [CIRC_W-1:0]     circ_r;
  logic [RATE_W-1:0]     rate_r;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic                  err_r, err_nxt;
  logic                  run_r, run_nxt;
  logic [DIST_WIDTH-1:0] dist_r, dist_nxt;
  logic [SPEED_W-1:0]    prev_r, prev_nxt;
  logic [SPEED_W-1:0]    cur_r, cur_nxt;
  logic [ACCEL_W-1:0]    acc_r, acc_nxt;
  logic [SPEED_W-1:0]    avg_r, avg_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic                  neg_r, neg_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  load_out;
  logic [SPEED_W-1:0]    o_speed_r;
  logic [ACCEL_W-1:0]    o_accel_r;
  logic [DIST_OUT_W-1:0] o_dist_r;
  logic [SPEED_W-1:0]    o_avg_r;
  logic [HOUR_OUT_W-1:0] o_hour_r;
  logic [MIN_W-1:0]      o_min_r;
  logic [SEC_W-1:0]      o_sec_r;
  logic                  o_run_r;
  logic                  o_err_r;

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  clk_ctl_t              clk_ctl;
  logic [HOUR_WIDTH-1:0] clk_hours;
  logic [MIN_W-1:0]      clk_minutes;
  logic [SEC_W-1:0]      clk_seconds;
  logic [SECS_W-1:0]     clk_total;

  logic                  accept;
  logic [DIST_WIDTH:0]   dist_sum;
  logic [SPEED_W-1:0]    dv;
  logic                  dv_neg;
  logic [ACCEL_W-1:0]    mag;
  logic [DIST_WIDTH+DIST_OUT_W-1:0] dist_ext;
  logic [HOUR_WIDTH+HOUR_OUT_W-1:0] hour_ext;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Drive the trip clock straight from the accepted event
  assign clk_ctl.tick  = accept && (in_opcode == OP_TICK) && run_r;
  assign clk_ctl.clear = accept && (in_opcode == OP_STOP);

  wtc_clock u_clock (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (clk_ctl),
    .hours   (clk_hours),
    .minutes (clk_minutes),
    .seconds (clk_seconds),
    .total   (clk_total)
  );

  wtc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_r <= CIRC_RESET;
      rate_r <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CIRC: circ_r <= cfg_wdata[CIRC_W-1:0];
        CFG_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    dist_sum = {1'b0, dist_r} + (DIST_WIDTH+1)'(circ_r);
    dv_neg   = (cur_r < prev_r);
    dv       = dv_neg ? (prev_r - cur_r) : (cur_r - prev_r);
    mag      = (div_rsp.quot > NUM_W'(ACC_POS_MAX)) ? ACC_POS_MAX
                                                    : div_rsp.quot[ACCEL_W-1:0];
    if (neg_r) begin
      mag = (div_rsp.quot > NUM_W'(ACC_NEG_MAX)) ? ACC_NEG_MAX
                                                 : div_rsp.quot[ACCEL_W-1:0];
    end
  end

  // Sequence one event through the shared divider
  always_comb begin
    state_nxt  = state_r;
    period_nxt = period_r;
    err_nxt    = err_r;
    run_nxt    = run_r;
    dist_nxt   = dist_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    acc_nxt    = acc_r;
    avg_nxt    = avg_r;
    prod_nxt   = prod_r;
    neg_nxt    = neg_r;
    div_req    = '0;
    load_out   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          period_nxt = in_period_ticks;
          err_nxt    = 1'b0;
          state_nxt  = S_FINISH;
          case (in_opcode)
            OP_TICK:  ;
            OP_PULSE: state_nxt = S_DIST;
            OP_PLAY:  run_nxt = 1'b1;
            OP_PAUSE: run_nxt = 1'b0;
            OP_STOP: begin
              run_nxt  = 1'b0;
              dist_nxt = '0;
              avg_nxt  = '0;
            end
            default:  ;
          endcase
        end
      end
      S_DIST: begin
        prod_nxt = PROD_W'(32'(circ_r) * 32'(rate_r));
        if (run_r) begin
          if (dist_sum > {1'b0, DIST_MAX}) begin
            dist_nxt = DIST_MAX;
            err_nxt  = 1'b1;
          end else begin
            dist_nxt = dist_sum[DIST_WIDTH-1:0];
          end
        end
        state_nxt = S_AVG;
      end
      S_AVG: begin
        state_nxt = S_SPD;
        if (run_r) begin
          if (clk_total == '0) begin
            err_nxt = 1'b1;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'({dist_r, 3'b000}) + NUM_W'(dist_r);
            div_req.den   = DEN_W'({clk_total, 4'b0000}) + DEN_W'({clk_total, 3'b000})
                          + DEN_W'(clk_total);
            state_nxt     = S_AVG_WAIT;
          end
        end
      end
      S_AVG_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > NUM_W'(SPEED_MAX)) begin
            avg_nxt = SPEED_MAX;
            err_nxt = 1'b1;
          end else begin
            avg_nxt = div_rsp.quot[SPEED_W-1:0];
          end
          state_nxt = S_SPD;
        end
      end
      S_SPD: begin
        if (period_r == '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'({prod_r[31:0], 3'b000}) + NUM_W'(prod_r[31:0]);
          div_req.den   = DEN_W'({period_r, 4'b0000}) + DEN_W'({period_r, 3'b000})
                        + DEN_W'(period_r);
          state_nxt     = S_SPD_WAIT;
        end
      end
      S_SPD_WAIT: begin
        if (div_rsp.done) begin
          prev_nxt = cur_r;
          if (div_rsp.quot > NUM_W'(SPEED_MAX)) begin
            cur_nxt = SPEED_MAX;
            err_nxt = 1'b1;
          end else begin
            cur_nxt = div_rsp.quot[SPEED_W-1:0];
          end
          state_nxt = S_ACC_MUL;
        end
      end
      S_ACC_MUL: begin
        prod_nxt  = PROD_W'(PROD_W'(dv) * PROD_W'(rate_r));
        neg_nxt   = dv_neg;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        // Scale by 3600 as 4096 - 512 + 16
        div_req.start = 1'b1;
        div_req.num   = NUM_W'({prod_r, 12'd0}) - NUM_W'({prod_r, 9'd0})
                      + NUM_W'({prod_r, 4'd0});
        div_req.den   = DEN_W'(period_r);
        state_nxt     = S_ACC_WAIT;
      end
      S_ACC_WAIT: begin
        if (div_rsp.done) begin
          if (neg_r) begin
            acc_nxt = ACCEL_W'(0) - mag;
            if (div_rsp.quot > NUM_W'(ACC_NEG_MAX)) err_nxt = 1'b1;
          end else begin
            acc_nxt = mag;
            if (div_rsp.quot > NUM_W'(ACC_POS_MAX)) err_nxt = 1'b1;
          end
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign dist_ext = {{DIST_OUT_W{1'b0}}, dist_r};
  assign hour_ext = {{HOUR_OUT_W{1'b0}}, clk_hours};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      run_r       <= 1'b0;
      dist_r      <= '0;
      prev_r      <= '0;
      cur_r       <= '0;
      acc_r       <= '0;
      avg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
      dist_r      <= dist_nxt;
      prev_r      <= prev_nxt;
      cur_r       <= cur_nxt;
      acc_r       <= acc_nxt;
      avg_r       <= avg_nxt;
    end
    period_r <= period_nxt;
    err_r    <= err_nxt;
    prod_r   <= prod_nxt;
    neg_r    <= neg_nxt;
    // Capture the finished event into the result register
    if (load_out) begin
      o_speed_r <= cur_r;
      o_accel_r <= acc_r;
      o_dist_r  <= dist_ext[DIST_OUT_W-1:0];
      o_avg_r   <= avg_r;
      o_hour_r  <= hour_ext[HOUR_OUT_W-1:0];
      o_min_r   <= clk_minutes;
      o_sec_r   <= clk_seconds;
      o_run_r   <= run_r;
      o_err_r   <= err_r;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_speed_centi_kmh       = o_speed_r;
  assign out_accel_centi_kmh_per_h = o_accel_r;
  assign out_trip_distance_mm      = o_dist_r;
  assign out_average_centi_kmh     = o_avg_r;
  assign out_trip_hour_count       = o_hour_r;
  assign out_trip_minute_count     = o_min_r;
  assign out_trip_second_count     = o_sec_r;
  assign out_is_running            = o_run_r;
  assign out_error_flag            = o_err_r;

`ifndef SYNTHESIS
  // The block takes one transaction at a time
  a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken while an event is in progress");

  // Quotients arrive only while the sequencer waits for one
  a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_AVG_WAIT || state_r == S_SPD_WAIT ||
                      state_r == S_ACC_WAIT))
    else $error("divider result arrived outside a wait state");

  // The trip clock never shows more than 59 minutes or seconds
  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_trip_minute_count <= MIN_LAST && out_trip_second_count <= SEC_LAST))
    else $error("trip clock out of range");

  // A result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");
`endif

endmodule

// File: src/wtc_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
module wtc_div
  import wtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Shift the next numerator bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      den_nxt  = req.den;
      quo_nxt  = req.num;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// File: src/wtc_clock.sv
// Trip clock: seconds, minutes, hours and a running total of seconds.
module wtc_clock
  import wtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  clk_ctl_t              ctl,
  output logic [HOUR_WIDTH-1:0] hours,
  output logic [MIN_W-1:0]      minutes,
  output logic [SEC_W-1:0]      seconds,
  output logic [SECS_W-1:0]     total
);

  logic [SEC_W-1:0]      sec_r, sec_nxt;
  logic [MIN_W-1:0]      min_r, min_nxt;
  logic [HOUR_WIDTH-1:0] hour_r, hour_nxt;
  logic [SECS_W-1:0]     total_r, total_nxt;
  logic                  sec_wrap, min_wrap, frozen;

  // Advance with carries; freeze at the top instead of wrapping the hours
  always_comb begin
    sec_wrap  = (sec_r >= SEC_LAST);
    min_wrap  = sec_wrap && (min_r >= MIN_LAST);
    frozen    = min_wrap && (hour_r >= HOUR_MAX);
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    total_nxt = total_r;
    if (ctl.clear) begin
      sec_nxt   = '0;
      min_nxt   = '0;
      hour_nxt  = '0;
      total_nxt = '0;
    end else if (ctl.tick && !frozen) begin
      total_nxt = total_r + SECS_W'(1);
      if (!sec_wrap) begin
        sec_nxt = sec_r + SEC_W'(1);
      end else begin
        sec_nxt = '0;
        if (!min_wrap) begin
          min_nxt = min_r + MIN_W'(1);
        end else begin
          min_nxt  = '0;
          hour_nxt = hour_r + HOUR_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
      total_r <= '0;
    end else begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      total_r <= total_nxt;
    end
  end

  assign hours   = hour_r;
  assign minutes = min_r;
  assign seconds = sec_r;
  assign total   = total_r;

endmodule

// File: tb/sv/wheel_trip_computer_unit_tb.sv
// Self-checking testbench for the wheel trip computer: scripted events, then random rides.
`timescale 1ns / 100ps

module wheel_trip_computer_unit_tb;
  import wtc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int RANDOM_EVENTS  = 1560;
  localparam int RIDE_PHASES    = 6;
  localparam int MINUTE_TICKS   = 130;

  // Event codes the block leaves alone
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [SPEED_W-1:0]        speed;
    logic signed [ACCEL_W-1:0] accel;
    logic [DIST_OUT_W-1:0]     distance;
    logic [SPEED_W-1:0]        average;
    logic [HOUR_OUT_W-1:0]     hours;
    logic [MIN_W-1:0]          minutes;
    logic [SEC_W-1:0]          seconds;
    logic                      running;
    logic                      fault;
  } trip_report_t;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [PERIOD_W-1:0] period;
    bit                  typed;
    trip_report_t        report;
  } scripted_event_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [OP_W-1:0]           in_opcode;
  logic [PERIOD_W-1:0]       in_period_ticks;
  logic                      out_valid;
  logic                      out_ready;
  logic [SPEED_W-1:0]        out_speed_centi_kmh;
  logic signed [ACCEL_W-1:0] out_accel_centi_kmh_per_h;
  logic [DIST_OUT_W-1:0]     out_trip_distance_mm;
  logic [SPEED_W-1:0]        out_average_centi_kmh;
  logic [HOUR_OUT_W-1:0]     out_trip_hour_count;
  logic [MIN_W-1:0]          out_trip_minute_count;
  logic [SEC_W-1:0]          out_trip_second_count;
  logic                      out_is_running;
  logic                      out_error_flag;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;

  // Predicted trip state and configuration
  logic [CIRC_W-1:0]         circ_mm;
  logic [RATE_W-1:0]         timer_hz;
  logic                      ride_on;
  logic [SEC_W-1:0]          sec_count;
  logic [MIN_W-1:0]          min_count;
  logic [HOUR_WIDTH-1:0]     hour_count;
  logic [DIST_WIDTH-1:0]     trip_mm;
  logic [SPEED_W-1:0]        last_speed;
  logic [SPEED_W-1:0]        speed_now;
  logic signed [ACCEL_W-1:0] accel_now;
  logic [SPEED_W-1:0]        avg_speed;

  trip_report_t pending_reports[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  bit           steady_flow = 1'b0;

  wheel_trip_computer_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the report that one event leaves behind, and advance the trip state
  function automatic trip_report_t advance_trip(input logic [OP_W-1:0] op,
                                                input logic [PERIOD_W-1:0] period);
    trip_report_t    rep;
    logic            fault;
    logic            neg;
    int unsigned     s, m, h;
    longint unsigned c, f, p, mm, secs, avg, v, mag;
    fault = 1'b0;
    c = circ_mm;
    f = timer_hz;
    p = period;
    case (op)
      OP_TICK: begin
        if (ride_on) begin
          s = sec_count + 1;
          m = min_count;
          h = hour_count;
          if (s >= 60) begin
            s = 0;
            m++;
          end
          // hold the whole clock at its top rather than wrap the hours
          if (!(m >= 60 && h >= HOUR_MAX)) begin
            if (m >= 60) begin
              m = 0;
              h++;
            end
            sec_count  = SEC_W'(s);
            min_count  = MIN_W'(m);
            hour_count = HOUR_WIDTH'(h);
          end
        end
      end
      OP_PULSE: begin
        // distance and average move only while the trip runs
        if (ride_on) begin
          mm = trip_mm + c;
          if (mm > DIST_MAX) begin
            mm = DIST_MAX;
            fault = 1'b1;
          end
          trip_mm = DIST_WIDTH'(mm);
          secs = 64'(hour_count) * 3600 + 64'(min_count) * 60 + 64'(sec_count);
          if (secs == 0) begin
            fault = 1'b1;
          end else begin
            avg = mm * 9 / (25 * secs);
            if (avg > SPEED_MAX) begin
              avg = SPEED_MAX;
              fault = 1'b1;
            end
            avg_speed = SPEED_W'(avg);
          end
        end
        // a zero period keeps speed and acceleration as they were
        if (p == 0) begin
          fault = 1'b1;
        end else begin
          v = c * f * 9 / (25 * p);
          if (v > SPEED_MAX) begin
            v = SPEED_MAX;
            fault = 1'b1;
          end
          last_speed = speed_now;
          speed_now  = SPEED_W'(v);
          neg = speed_now < last_speed;
          mag = neg ? 64'(last_speed) - 64'(speed_now) : 64'(speed_now) - 64'(last_speed);
          mag = mag * f * 3600 / p;
          if (neg) begin
            if (mag > 64'h8000_0000) begin
              mag = 64'h8000_0000;
              fault = 1'b1;
            end
            accel_now = ACCEL_W'(64'd0 - mag);
          end else begin
            if (mag > 64'h7FFF_FFFF) begin
              mag = 64'h7FFF_FFFF;
              fault = 1'b1;
            end
            accel_now = ACCEL_W'(mag);
          end
        end
      end
      OP_PLAY:  ride_on = 1'b1;
      OP_PAUSE: ride_on = 1'b0;
      OP_STOP: begin
        ride_on    = 1'b0;
        sec_count  = '0;
        min_count  = '0;
        hour_count = '0;
        trip_mm    = '0;
        avg_speed  = '0;
      end
      default: ;
    endcase
    rep.speed    = speed_now;
    rep.accel    = accel_now;
    rep.distance = DIST_OUT_W'(trip_mm);
    rep.average  = avg_speed;
    rep.hours    = HOUR_OUT_W'(hour_count);
    rep.minutes  = min_count;
    rep.seconds  = sec_count;
    rep.running  = ride_on;
    rep.fault    = fault;
    return rep;
  endfunction

  // Report of a bike that has not moved: only distance, seconds and the flags vary
  function automatic trip_report_t at_rest(input logic [DIST_OUT_W-1:0] mm,
                                           input logic [SEC_W-1:0] s,
                                           input logic run, input logic fault);
    trip_report_t rep;
    rep = '{'0, '0, mm, '0, '0, '0, s, run, fault};
    return rep;
  endfunction

  // Mostly plausible wheel periods, with zero, tiny and arbitrary ones mixed in
  function automatic logic [PERIOD_W-1:0] draw_period();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return PERIOD_W'($urandom_range(1, 16));
    if (pick == 2) return $urandom();
    return PERIOD_W'($urandom_range(1, 4 * timer_hz + 16));
  endfunction

  // Offer one event after a random gap, then log its report once it is taken
  task automatic ride_event(input logic [OP_W-1:0] op, input logic [PERIOD_W-1:0] period,
                            input bit typed, input trip_report_t report);
    int           gap;
    trip_report_t predicted;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_period_ticks <= period;
    do @(posedge clk); while (!in_ready);
    predicted = advance_trip(op, period);
    pending_reports.push_back(typed ? report : predicted);
    @(negedge clk);
  endtask

  // Drop valid, let every report drain, then give the block time to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_CIRC) circ_mm = data[CIRC_W-1:0];
    else timer_hz = data[RATE_W-1:0];
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transaction with the oldest predicted report
  always @(posedge clk) begin : report_check
    trip_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction arrived with no report pending");
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("speed_centi_kmh", want.speed, out_speed_centi_kmh);
        check_field("accel_centi_kmh_per_h", want.accel, out_accel_centi_kmh_per_h);
        check_field("trip_distance_mm", want.distance, out_trip_distance_mm);
        check_field("average_centi_kmh", want.average, out_average_centi_kmh);
        check_field("trip_hour_count", want.hours, out_trip_hour_count);
        check_field("trip_minute_count", want.minutes, out_trip_minute_count);
        check_field("trip_second_count", want.seconds, out_trip_second_count);
        check_field("is_running", want.running, out_is_running);
        check_field("error_flag", want.fault, out_error_flag);
      end
    end
  end

  // Abort when neither channel has moved for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before taking each transaction
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    scripted_event_t script[$];
    trip_report_t    blank;
    logic [OP_W-1:0] op;
    int unsigned     pick;
    in_valid        <= 1'b0;
    in_opcode       <= OP_TICK;
    in_period_ticks <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_CIRC;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;

    // predicted state after reset
    circ_mm    = CIRC_RESET;
    timer_hz   = RATE_RESET;
    ride_on    = 1'b0;
    sec_count  = '0;
    min_count  = '0;
    hour_count = '0;
    trip_mm    = '0;
    last_speed = '0;
    speed_now  = '0;
    accel_now  = '0;
    avg_speed  = '0;
    blank      = at_rest('0, '0, 1'b0, 1'b0);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Scripted opening: idle ticks, spare codes, zero periods, zero trip time,
    // period extremes, pause and stop
    script.push_back('{OP_TICK,    32'd0,         1'b1, at_rest('0, '0, 1'b0, 1'b0)});
    script.push_back('{OP_SPARE_7, 32'hFFFF_FFFF, 1'b1, at_rest('0, '0, 1'b0, 1'b0)});
    script.push_back('{OP_PULSE,   32'd0,         1'b1, at_rest('0, '0, 1'b0, 1'b1)});
    script.push_back('{OP_PLAY,    32'd0,         1'b1, at_rest('0, '0, 1'b1, 1'b0)});
    script.push_back('{OP_PLAY,    32'hFFFF_FFFF, 1'b1, at_rest('0, '0, 1'b1, 1'b0)});
    script.push_back('{OP_PULSE,   32'd0,         1'b1, at_rest(40'd1596, '0, 1'b1, 1'b1)});
    script.push_back('{OP_TICK,    32'd0,         1'b1, at_rest(40'd1596, 6'd1, 1'b1, 1'b0)});
    script.push_back('{OP_PULSE,   32'd1000,      1'b0, blank});
    script.push_back('{OP_PULSE,   32'd1,         1'b0, blank});
    script.push_back('{OP_PULSE,   32'hFFFF_FFFF, 1'b0, blank});
    script.push_back('{OP_SPARE_5, 32'h1234_5678, 1'b0, blank});
    script.push_back('{OP_PAUSE,   32'd0,         1'b0, blank});
    script.push_back('{OP_TICK,    32'd0,         1'b0, blank});
    script.push_back('{OP_PULSE,   32'd500,       1'b0, blank});
    script.push_back('{OP_PAUSE,   32'd0,         1'b0, blank});
    script.push_back('{OP_SPARE_6, 32'd0,         1'b0, blank});
    script.push_back('{OP_STOP,    32'd0,         1'b0, blank});
    script.push_back('{OP_TICK,    32'd0,         1'b0, blank});
    script.push_back('{OP_PLAY,    32'd0,         1'b0, blank});
    script.push_back('{OP_PULSE,   32'h5555_5555, 1'b0, blank});
    script.push_back('{OP_TICK,    32'd0,         1'b0, blank});
    script.push_back('{OP_PULSE,   32'hAAAA_AAAA, 1'b0, blank});
    script.push_back('{OP_STOP,    32'd0,         1'b0, blank});
    foreach (script[k]) ride_event(script[k].op, script[k].period, script[k].typed,
                                   script[k].report);

    // Random rides, one wheel and timer setting per phase
    for (int phase = 0; phase < RIDE_PHASES; phase++) begin
      case (phase)
        1: begin
          write_register(CFG_CIRC, 20'h00FFF);
          write_register(CFG_RATE, 20'hFFFFF);
        end
        2: begin
          write_register(CFG_CIRC, 20'd0);
          write_register(CFG_RATE, 20'd0);
        end
        3: begin
          write_register(CFG_CIRC, 20'd500);
          write_register(CFG_RATE, 20'd1);
        end
        4: begin
          write_register(CFG_CIRC, 20'd2100);
          write_register(CFG_RATE, 20'd1000000);
        end
        5: begin
          write_register(CFG_CIRC, CFG_DATA_W'($urandom_range(500, 4000)));
          write_register(CFG_RATE, CFG_DATA_W'($urandom_range(1, 20'hFFFFF)));
        end
        default: ;
      endcase
      for (int i = 0; i < RANDOM_EVENTS / RIDE_PHASES; i++) begin
        if (i % 40 == 0) steady_flow = ($urandom_range(0, 4) == 0);
        // mostly a running trip: ticks and pulses, play often, stop rarely
        pick = $urandom_range(0, 99);
        if (pick < 35) op = OP_TICK;
        else if (pick < 80) op = OP_PULSE;
        else if (pick < 87) op = OP_PLAY;
        else if (pick < 92) op = OP_PAUSE;
        else if (pick < 95) op = OP_STOP;
        else begin
          case ($urandom_range(0, 2))
            0:       op = OP_SPARE_5;
            1:       op = OP_SPARE_6;
            default: op = OP_SPARE_7;
          endcase
        end
        ride_event(op, (op == OP_PULSE) ? draw_period() : $urandom(), 1'b0, blank);
      end
    end

    // One long ride, past the second minute of the trip clock
    steady_flow = 1'b0;
    ride_event(OP_STOP, '0, 1'b0, blank);
    ride_event(OP_PLAY, '0, 1'b0, blank);
    for (int t = 0; t < MINUTE_TICKS; t++) begin
      if (t % 50 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      ride_event(OP_TICK, $urandom(), 1'b0, blank);
      if (t % 30 == 0) ride_event(OP_PULSE, draw_period(), 1'b0, blank);
    end

    steady_flow = 1'b0;
    settle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
